[rtl/sprite_table_blit_collide_top_defines.svh]
// Assertion macros for the sprite table block.
`ifndef SPRITE_TABLE_BLIT_COLLIDE_TOP_DEFINES_SVH
`define SPRITE_TABLE_BLIT_COLLIDE_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define STBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define STBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/stbc_pkg.sv]
// Shared types and codes for the sprite table block.
`timescale 1ns / 1ps

package stbc_pkg;

    localparam logic [2:0] MODE_CREATE  = 3'd0;
    localparam logic [2:0] MODE_MOTION  = 3'd1;
    localparam logic [2:0] MODE_RELEASE = 3'd2;
    localparam logic [2:0] MODE_TICK    = 3'd3;
    localparam logic [2:0] MODE_COLLIDE = 3'd4;
    localparam logic [2:0] MODE_DRAW    = 3'd5;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [9:0]  SCREEN_RESET      = 10'd320;
    localparam logic [15:0] TRANSPARENT_COLOR = 16'hFFFF;

    typedef struct packed {
        logic [2:0]         mode;
        logic [3:0]         slot;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [9:0]         size_w;
        logic [9:0]         size_h;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic [7:0]         kind;
        logic               has_image;
        logic [15:0]        pixel_color;
    } req_t;

    typedef struct packed {
        logic        create_ok;
        logic [3:0]  created_slot;
        logic [15:0] collide_mask;
        logic        write_enable;
        logic [19:0] fb_address;
        logic [15:0] fb_color;
    } rsp_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [9:0]  width;
        logic [9:0]  height;
        logic [15:0] vel_x;
        logic [15:0] vel_y;
        logic [7:0]  kind;
    } slot_rec_t;

endpackage

[rtl/stbc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module stbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sprite_table_blit_collide_top.sv]
// Sprite table engine: create, motion, release, tick, collide and pixel draw.
// One request is taken at a time; req_stall stays high from acceptance until
// its response has been taken. Slot records live in one RAM with a registered
// read port, so the sequencer passes through a read state before using any record.
// Steps per request, N = NUM_SLOTS: release, unused modes, out-of-range motion,
// collide or draw, collide on a hidden slot and draw on a hidden or imageless
// slot go straight to the response; set motion reads, then writes back; create
// scans to the lowest free slot, all N slots when the table is full; tick
// reads, then adds and writes back per slot; collide on slot q reads it, then
// compares slots q+1 to min(N,16) - 1; draw: read, clip check, address multiply.
// The per-slot read/update loop over the shared RAM port sets tick and
// collide time. Visible and image bits are flip-flops cleared at reset; no
// clearing pass is needed since a record is only used once create wrote it.
// The screen size registers (scr_w_reg, scr_h_reg) are to be written through
// cfg_* only while idle, not enforced by the block; cfg_ready is always high.
`timescale 1ns / 1ps

module sprite_table_blit_collide_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  stbc_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output stbc_pkg::rsp_t rsp_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_index,
    input  logic [9:0]    cfg_data
);

    import stbc_pkg::*;

    localparam int IDX_W   = $clog2(NUM_SLOTS);
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int COL_END = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
    localparam int REC_W   = $bits(slot_rec_t);

    // sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CREATE    = 4'd1;
    localparam logic [3:0] ST_MOTION_RD = 4'd2;
    localparam logic [3:0] ST_MOTION_WR = 4'd3;
    localparam logic [3:0] ST_TICK_RD   = 4'd4;
    localparam logic [3:0] ST_TICK_WR   = 4'd5;
    localparam logic [3:0] ST_COL_REF   = 4'd6;
    localparam logic [3:0] ST_COL_LATCH = 4'd7;
    localparam logic [3:0] ST_COL_RD    = 4'd8;
    localparam logic [3:0] ST_COL_CMP   = 4'd9;
    localparam logic [3:0] ST_DRAW_RD   = 4'd10;
    localparam logic [3:0] ST_DRAW_CHK  = 4'd11;
    localparam logic [3:0] ST_DRAW_ADDR = 4'd12;
    localparam logic [3:0] ST_DONE      = 4'd13;

    logic [3:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [NUM_SLOTS-1:0] vis_reg, vis_next;
    logic [NUM_SLOTS-1:0] img_reg, img_next;
    logic [9:0]           scr_w_reg, scr_h_reg;

    req_t      req_reg, req_next;
    rsp_t      rsp_reg, rsp_next;
    slot_rec_t ref_reg, ref_next;
    logic      hit_reg, hit_next;
    logic [9:0] sx_reg, sx_next, sy_reg, sy_next;

    // RAM port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    slot_rec_t        ram_wdata, ram_rdata;
    logic [REC_W-1:0] ram_rdata_raw;

    logic [IDX_W-1:0] cnt_idx, req_idx, in_idx;
    logic             in_table_new;

    // shared compare datapath
    logic signed [17:0] ax, ay, bx, by, aw, ah, bw, bh;
    logic               overlap;
    logic signed [17:0] ox, oy, sx, sy;
    logic               off_ok, scr_ok;

    assign cnt_idx      = cnt_reg[IDX_W-1:0];
    assign req_idx      = IDX_W'(req_reg.slot);
    assign in_idx       = IDX_W'(req_data.slot);
    assign in_table_new = (NUM_SLOTS >= 16) || (int'(req_data.slot) < NUM_SLOTS);

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = (state_reg == ST_DONE);
    assign rsp_data  = rsp_reg;
    assign cfg_ready = 1'b1;

    // Overlap: reference slot (a) against the record just read (b).
    assign ax = {{2{ref_reg.pos_x[15]}}, ref_reg.pos_x};
    assign ay = {{2{ref_reg.pos_y[15]}}, ref_reg.pos_y};
    assign aw = {8'd0, ref_reg.width};
    assign ah = {8'd0, ref_reg.height};
    assign bx = {{2{ram_rdata.pos_x[15]}}, ram_rdata.pos_x};
    assign by = {{2{ram_rdata.pos_y[15]}}, ram_rdata.pos_y};
    assign bw = {8'd0, ram_rdata.width};
    assign bh = {8'd0, ram_rdata.height};
    assign overlap = (ax < bx + bw) && (ax + aw > bx) && (ay < by + bh) && (ay + ah > by);

    // Draw clipping: offset inside sprite, then on screen.
    assign ox = {{2{req_reg.pos_x[15]}}, req_reg.pos_x};
    assign oy = {{2{req_reg.pos_y[15]}}, req_reg.pos_y};
    assign sx = bx + ox;
    assign sy = by + oy;
    assign off_ok = !ox[17] && (ox < bw) && !oy[17] && (oy < bh);
    assign scr_ok = !sx[17] && (sx < $signed({8'd0, scr_w_reg}))
                 && !sy[17] && (sy < $signed({8'd0, scr_h_reg}))
                 && (req_reg.pixel_color != TRANSPARENT_COLOR);

    assign ram_rdata = slot_rec_t'(ram_rdata_raw);

    stbc_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (REC_W'(ram_wdata)),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        vis_next   = vis_reg;
        img_next   = img_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        ref_next   = ref_reg;
        hit_next   = hit_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        ram_we     = 1'b0;
        ram_waddr  = cnt_idx;
        ram_wdata  = ram_rdata;
        ram_raddr  = cnt_idx;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_data;
                    rsp_next = '0;
                    cnt_next = '0;
                    state_next = ST_DONE;
                    case (req_data.mode)
                        MODE_CREATE:  state_next = ST_CREATE;
                        MODE_MOTION:
                        begin
                            if (in_table_new)
                            begin
                                state_next = ST_MOTION_RD;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            if (in_table_new)
                            begin
                                vis_next[in_idx] = 1'b0;
                            end
                        end
                        MODE_TICK:    state_next = ST_TICK_RD;
                        MODE_COLLIDE:
                        begin
                            if (in_table_new && vis_reg[in_idx])
                            begin
                                state_next = ST_COL_REF;
                            end
                        end
                        MODE_DRAW:
                        begin
                            if (in_table_new && vis_reg[in_idx] && img_reg[in_idx])
                            begin
                                state_next = ST_DRAW_RD;
                            end
                        end
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_CREATE:
            begin
                if (int'(cnt_reg) >= NUM_SLOTS)
                begin
                    state_next = ST_DONE;  // table full
                end
                else if (!vis_reg[cnt_idx])
                begin
                    ram_we           = 1'b1;
                    ram_wdata.pos_x  = req_reg.pos_x;
                    ram_wdata.pos_y  = req_reg.pos_y;
                    ram_wdata.width  = req_reg.size_w;
                    ram_wdata.height = req_reg.size_h;
                    ram_wdata.vel_x  = '0;
                    ram_wdata.vel_y  = '0;
                    ram_wdata.kind   = req_reg.kind;
                    vis_next[cnt_idx] = 1'b1;
                    img_next[cnt_idx] = req_reg.has_image;
                    rsp_next.create_ok    = 1'b1;
                    rsp_next.created_slot = 4'(cnt_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_MOTION_RD:
            begin
                ram_raddr  = req_idx;
                state_next = ST_MOTION_WR;
            end
            ST_MOTION_WR:
            begin
                ram_we          = 1'b1;
                ram_waddr       = req_idx;
                ram_wdata.vel_x = req_reg.vel_x;
                ram_wdata.vel_y = req_reg.vel_y;
                state_next      = ST_DONE;
            end
            ST_TICK_RD:
            begin
                state_next = ST_TICK_WR;
            end
            ST_TICK_WR:
            begin
                ram_we          = vis_reg[cnt_idx];
                ram_wdata.pos_x = ram_rdata.pos_x + ram_rdata.vel_x;
                ram_wdata.pos_y = ram_rdata.pos_y + ram_rdata.vel_y;
                cnt_next        = cnt_reg + CNT_W'(1);
                state_next      = (int'(cnt_reg) + 1 >= NUM_SLOTS) ? ST_DONE : ST_TICK_RD;
            end
            ST_COL_REF:
            begin
                ram_raddr  = req_idx;
                state_next = ST_COL_LATCH;
            end
            ST_COL_LATCH:
            begin
                ref_next   = ram_rdata;
                cnt_next   = CNT_W'(req_reg.slot) + CNT_W'(1);
                state_next = (int'(req_reg.slot) + 1 >= COL_END) ? ST_DONE : ST_COL_RD;
            end
            ST_COL_RD:
            begin
                state_next = ST_COL_CMP;
            end
            ST_COL_CMP:
            begin
                if (vis_reg[cnt_idx] && overlap)
                begin
                    rsp_next.collide_mask = rsp_reg.collide_mask | (16'd1 << cnt_reg);
                end
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = (int'(cnt_reg) + 1 >= COL_END) ? ST_DONE : ST_COL_RD;
            end
            ST_DRAW_RD:
            begin
                ram_raddr  = req_idx;
                state_next = ST_DRAW_CHK;
            end
            ST_DRAW_CHK:
            begin
                hit_next   = off_ok && scr_ok;
                sx_next    = sx[9:0];
                sy_next    = sy[9:0];
                state_next = ST_DRAW_ADDR;
            end
            ST_DRAW_ADDR:
            begin
                if (hit_reg)
                begin
                    rsp_next.write_enable = 1'b1;
                    rsp_next.fb_address   = 20'(sy_reg) * 20'(scr_w_reg) + 20'(sx_reg);
                    rsp_next.fb_color     = req_reg.pixel_color;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            vis_reg   <= '0;
            img_reg   <= '0;
            scr_w_reg <= SCREEN_RESET;
            scr_h_reg <= SCREEN_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            vis_reg   <= vis_next;
            img_reg   <= img_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data;
                    REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data;
                    default:           scr_w_reg <= scr_w_reg;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        ref_reg <= ref_next;
        hit_reg <= hit_next;
        sx_reg  <= sx_next;
        sy_reg  <= sy_next;
    end

endmodule

[rtl/stbc_checker.sv]
// Port-level checks for the sprite table block, bound to the top level.
`timescale 1ns / 1ps
`include "sprite_table_blit_collide_top_defines.svh"

module stbc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input stbc_pkg::req_t req_data,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input stbc_pkg::rsp_t rsp_data
);

    import stbc_pkg::*;

    `STBC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "response changed while stalled")
    `STBC_ASSERT_NOW(a_no_accept_pending, req_valid && !req_stall, !rsp_valid, "request taken while response pending")
    `STBC_ASSERT_NOW(a_busy_pending, rsp_valid, req_stall, "not stalled while response pending")
    `STBC_ASSERT_NOW(a_no_write_zero, rsp_valid && !rsp_data.write_enable, (rsp_data.fb_address == 20'd0) && (rsp_data.fb_color == 16'd0), "write fields set without write")
    `STBC_ASSERT_NOW(a_fail_slot_zero, rsp_valid && !rsp_data.create_ok, rsp_data.created_slot == 4'd0, "slot set without create")

endmodule

bind sprite_table_blit_collide_top stbc_checker u_stbc_checker (.*);
